// ===== src/cilm_pkg.sv =====
// Shared types and constants for the CPU idle load monitor.
package cilm_pkg;

  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_SWITCH = 2'd1;
  localparam logic [1:0] FUNC_SAMPLE = 2'd2;

  localparam logic [31:0] MIN_WINDOW_RESET = 32'd16000000;
  localparam logic [9:0]  PERMILLE_FULL    = 10'd1000;
  localparam int          QUOT_BITS        = 10;

  // Status of one bit-serial pass, valid when done is high.
  typedef struct packed {
    logic done;
    logic below_min;
    logic ready;
  } ser_stat_t;

endpackage

// ===== src/cilm_serial.sv =====
// Bit-serial datapath: idle total, window length, idle delta and both compares, LSB first.
module cilm_serial
  import cilm_pkg::*;
#(
  parameter int CW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   now_i,
  input  logic [CW-1:0] last_i,
  input  logic [CW-1:0] accum_i,
  input  logic [CW-1:0] wstart_i,
  input  logic [CW-1:0] widle_i,
  input  logic [31:0]   minw_i,
  input  logic          cur_idle_i,
  output logic [CW-1:0] idle_o,
  output logic [CW-1:0] total_o,
  output logic [CW-1:0] delta_o,
  output ser_stat_t     stat_o
);

  localparam int L  = (CW > 32) ? CW : 32;
  localparam int IW = $clog2(L);

  function automatic logic borrow_f(input logic a, input logic b, input logic bin);
    return (~a & b) | (~(a ^ b) & bin);
  endfunction

  function automatic logic carry_f(input logic a, input logic b, input logic cin);
    return (a & b) | (cin & (a ^ b));
  endfunction

  logic [L-1:0]  now_sr_r, last_sr_r, acc_sr_r, ws_sr_r, wi_sr_r, min_sr_r;
  logic [L-1:0]  idle_sr_r, tot_sr_r, dl_sr_r;
  logic          b1_r, c2_r, b3_r, b4_r, b5_r, b6_r;
  logic          cur_r;
  logic          busy_r;
  logic          done_r, below_r, ready_r;
  logic [IW-1:0] cnt_r;

  logic in_range;
  logic d_bit, add_bit, idl_bit, t_bit, dl_bit;
  logic tm, dlm, idlm;
  logic b1_nxt, c2_nxt, b3_nxt, b4_nxt, b5_nxt, b6_nxt;

  always_comb begin
    in_range = ({1'b0, cnt_r} < (IW+1)'(CW));
    d_bit    = now_sr_r[0] ^ last_sr_r[0] ^ b1_r;
    b1_nxt   = borrow_f(now_sr_r[0], last_sr_r[0], b1_r);
    add_bit  = cur_r & d_bit;
    idl_bit  = acc_sr_r[0] ^ add_bit ^ c2_r;
    c2_nxt   = carry_f(acc_sr_r[0], add_bit, c2_r);
    t_bit    = now_sr_r[0] ^ ws_sr_r[0] ^ b3_r;
    b3_nxt   = borrow_f(now_sr_r[0], ws_sr_r[0], b3_r);
    dl_bit   = idl_bit ^ wi_sr_r[0] ^ b4_r;
    b4_nxt   = borrow_f(idl_bit, wi_sr_r[0], b4_r);
    // bits above the counter width are zero after the modulo
    tm       = t_bit & in_range;
    dlm      = dl_bit & in_range;
    idlm     = idl_bit & in_range;
    b5_nxt   = borrow_f(tm, min_sr_r[0], b5_r);
    b6_nxt   = borrow_f(tm, dlm, b6_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == IW'(L - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      now_sr_r  <= L'(now_i);
      last_sr_r <= L'(last_i);
      acc_sr_r  <= L'(accum_i);
      ws_sr_r   <= L'(wstart_i);
      wi_sr_r   <= L'(widle_i);
      min_sr_r  <= L'(minw_i);
      cur_r     <= cur_idle_i;
      {b1_r, c2_r, b3_r, b4_r, b5_r, b6_r} <= '0;
    end else if (busy_r) begin
      now_sr_r  <= now_sr_r >> 1;
      last_sr_r <= last_sr_r >> 1;
      acc_sr_r  <= acc_sr_r >> 1;
      ws_sr_r   <= ws_sr_r >> 1;
      wi_sr_r   <= wi_sr_r >> 1;
      min_sr_r  <= min_sr_r >> 1;
      idle_sr_r <= {idlm, idle_sr_r[L-1:1]};
      tot_sr_r  <= {tm, tot_sr_r[L-1:1]};
      dl_sr_r   <= {dlm, dl_sr_r[L-1:1]};
      b1_r      <= b1_nxt;
      c2_r      <= c2_nxt;
      b3_r      <= b3_nxt;
      b4_r      <= b4_nxt;
      b5_r      <= b5_nxt;
      b6_r      <= b6_nxt;
      if (cnt_r == IW'(L - 1)) begin
        below_r <= b5_nxt;
        ready_r <= ~b6_nxt;
      end
    end
  end

  assign idle_o           = idle_sr_r[CW-1:0];
  assign total_o          = tot_sr_r[CW-1:0];
  assign delta_o          = dl_sr_r[CW-1:0];
  assign stat_o.done      = done_r;
  assign stat_o.below_min = below_r;
  assign stat_o.ready     = ready_r;

endmodule

// ===== src/cilm_div.sv =====
// Restoring divider: floor(1000 * x / t), one quotient bit per cycle.
module cilm_div
  import cilm_pkg::*;
#(
  parameter int CW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [CW-1:0]        x_i,
  input  logic [CW-1:0]        t_i,
  output logic [QUOT_BITS-1:0] q_o,
  output logic                 done_o
);

  localparam int NW = CW + QUOT_BITS;

  logic [NW-1:0]        n_scaled;
  logic [CW-1:0]        rem_r, t_r;
  logic [QUOT_BITS-1:0] nlo_r, q_r;
  logic [3:0]           cnt_r;
  logic                 busy_r, done_r;
  logic [CW:0]          r2, diff;
  logic                 ge;

  always_comb begin
    // 1000*x = 1024*x - 16*x - 8*x
    n_scaled = {x_i, {QUOT_BITS{1'b0}}} - (NW'(x_i) << 4) - (NW'(x_i) << 3);
    r2       = {rem_r, nlo_r[QUOT_BITS-1]};
    diff     = r2 - {1'b0, t_r};
    ge       = (r2 >= {1'b0, t_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 4'(QUOT_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= n_scaled[NW-1:QUOT_BITS];
      nlo_r <= n_scaled[QUOT_BITS-1:0];
      t_r   <= t_i;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[CW-1:0] : r2[CW-1:0];
      nlo_r <= nlo_r << 1;
      q_r   <= {q_r[QUOT_BITS-2:0], ge};
    end
  end

  assign q_o    = q_r;
  assign done_o = done_r;

endmodule

// ===== src/cpu_idle_load_monitor.sv =====
// CPU load monitor top level: event handling, window state and result register.
// Start request: taken directly in the idle state. Switch request: one bit-serial pass.
// Sample request: serial pass, 10-step divider, result load to out_valid; a window below
// the minimum ends after the serial pass. The result load waits while out_stall holds a result.
// Synchronous active-low reset: block stopped, min window 16000000, output empty.
module cpu_idle_load_monitor
  import cilm_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_now_cycles,
  input  logic        in_to_idle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_win_total,
  output logic [31:0] out_win_idle,
  output logic        out_ready_res,
  output logic [9:0]  out_busy_permille,
  output logic [31:0] out_sequence_res
);

  localparam int CW = COUNT_WIDTH;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SER  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]    state_r;
  logic          running_r, cur_idle_r, to_idle_r, is_sample_r;
  logic [CW-1:0] last_r, acc_r, ws_r, wi_r, now_r;
  logic [CW-1:0] total_r, delta_r;
  logic          ready_r;
  logic [9:0]    busy_r;
  logic [31:0]   pub_r, minw_r;

  logic          out_valid_r, out_ready_r;
  logic [31:0]   out_total_r, out_idle_r, out_seq_r;
  logic [9:0]    out_busy_r;

  logic          in_acc, ser_start, div_start;
  logic [CW-1:0] ser_idle, ser_total, ser_delta;
  ser_stat_t     ser_stat;
  logic [9:0]    div_q;
  logic          div_done;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign ser_start = in_acc & running_r & ((in_func == FUNC_SWITCH) | (in_func == FUNC_SAMPLE));
  assign div_start = (state_r == S_SER) & ser_stat.done & is_sample_r & ~ser_stat.below_min;

  cilm_serial #(.CW(CW)) u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (ser_start),
    .now_i      (in_now_cycles),
    .last_i     (last_r),
    .accum_i    (acc_r),
    .wstart_i   (ws_r),
    .widle_i    (wi_r),
    .minw_i     (minw_r),
    .cur_idle_i (cur_idle_r),
    .idle_o     (ser_idle),
    .total_o    (ser_total),
    .delta_o    (ser_delta),
    .stat_o     (ser_stat)
  );

  cilm_div #(.CW(CW)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .x_i    (ser_delta),
    .t_i    (ser_total),
    .q_o    (div_q),
    .done_o (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minw_r <= MIN_WINDOW_RESET;
    end else if (cfg_wr_en) begin
      minw_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      running_r   <= 1'b0;
      cur_idle_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // result register is free or being drained this cycle
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_func == FUNC_START) begin
            running_r  <= 1'b1;
            cur_idle_r <= 1'b0;
          end else if (ser_start) begin
            state_r <= S_SER;
          end
        end
        S_SER: begin
          if (ser_stat.done) begin
            if (!is_sample_r) begin
              cur_idle_r <= to_idle_r;
              state_r    <= S_IDLE;
            end else if (ser_stat.below_min) begin
              state_r <= S_IDLE;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc) begin
      if (in_func == FUNC_START) begin
        acc_r <= '0;
        wi_r  <= '0;
        last_r <= CW'(in_now_cycles);
        ws_r  <= CW'(in_now_cycles);
        pub_r <= '0;
      end
      now_r       <= CW'(in_now_cycles);
      to_idle_r   <= in_to_idle;
      is_sample_r <= (in_func == FUNC_SAMPLE);
    end
    if (state_r == S_SER && ser_stat.done) begin
      if (!is_sample_r) begin
        acc_r  <= ser_idle;
        last_r <= now_r;
      end else if (!ser_stat.below_min) begin
        ws_r    <= now_r;
        wi_r    <= ser_idle;
        pub_r   <= pub_r + 32'd1;
        total_r <= ser_total;
        delta_r <= ser_delta;
        ready_r <= ser_stat.ready;
      end
    end
    if (state_r == S_DIV && div_done) begin
      busy_r <= (ready_r && total_r != '0) ? (PERMILLE_FULL - div_q) : 10'd0;
    end
    if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
      out_total_r <= 32'(total_r);
      out_idle_r  <= 32'(delta_r);
      out_ready_r <= ready_r;
      out_busy_r  <= busy_r;
      out_seq_r   <= pub_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_win_total     = out_total_r;
  assign out_win_idle      = out_idle_r;
  assign out_ready_res     = out_ready_r;
  assign out_busy_permille = out_busy_r;
  assign out_sequence_res  = out_seq_r;

endmodule
